/* src/fbsc_pkg.sv */
`default_nettype none

package fbsc_pkg;

  localparam int COORD_W = 32;
  localparam int SLOT_W  = 3;
  localparam int REQ_W   = 2;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int SUM_W   = PROD_W + 2;

  typedef logic [REQ_W-1:0] req_t;

  localparam req_t REQ_WRITE  = 2'd0;
  localparam req_t REQ_BOX    = 2'd1;
  localparam req_t REQ_SPHERE = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic              valid;
    req_t              req;
    logic [SLOT_W-1:0] slot;
    coord_t            lo_x;
    coord_t            lo_y;
    coord_t            lo_z;
    coord_t            hi_x;
    coord_t            hi_y;
    coord_t            hi_z;
    coord_t            radius;
    coord_t            offset;
    logic              in_view;
  } item_t;

endpackage

`default_nettype wire

/* src/fbsc_cell.sv */
`default_nettype none

module fbsc_cell #(
  parameter int PLANE_IDX = 0,
  parameter int FRAC_BITS = 16,
  parameter int DIST_W    = 51
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire fbsc_pkg::item_t          in_item,
  input  wire logic signed [DIST_W-1:0] in_best,
  output fbsc_pkg::item_t               out_item,
  output logic signed [DIST_W-1:0]      out_best
);
  import fbsc_pkg::*;

  localparam int SH_W = SUM_W - FRAC_BITS;

  coord_t nx_r, ny_r, nz_r, off_r;
  logic   wr_hit;

  item_t                     s1_item_r;
  logic signed [PROD_W-1:0]  s1_px_r, s1_py_r, s1_pz_r;
  logic signed [PROD_W-1:0]  px_nxt, py_nxt, pz_nxt;
  coord_t                    s1_off_r;
  logic signed [DIST_W-1:0]  s1_best_r;
  coord_t                    vx, vy, vz;
  logic                      is_box;

  item_t                     s2_item_r;
  logic signed [DIST_W-1:0]  s2_d_r, s2_best_r, d_nxt;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SH_W-1:0]    sum_sh;

  item_t                     s3_item_r, s3_item_nxt;
  logic signed [DIST_W-1:0]  s3_best_r, best_nxt, neg_rad;
  logic                      fail;

  assign wr_hit = en && in_item.valid && (in_item.req == REQ_WRITE) &&
                  (PLANE_IDX < (1 << SLOT_W)) && (in_item.slot == SLOT_W'(PLANE_IDX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r  <= '0;
      ny_r  <= '0;
      nz_r  <= '0;
      off_r <= '0;
    end else if (wr_hit) begin
      nx_r  <= in_item.lo_x;
      ny_r  <= in_item.lo_y;
      nz_r  <= in_item.lo_z;
      off_r <= in_item.offset;
    end
  end

  // positive vertex for boxes, centre otherwise
  assign is_box = (in_item.req == REQ_BOX);
  assign vx = (is_box && !nx_r[COORD_W-1]) ? in_item.hi_x : in_item.lo_x;
  assign vy = (is_box && !ny_r[COORD_W-1]) ? in_item.hi_y : in_item.lo_y;
  assign vz = (is_box && !nz_r[COORD_W-1]) ? in_item.hi_z : in_item.lo_z;
  assign px_nxt = nx_r * vx;
  assign py_nxt = ny_r * vy;
  assign pz_nxt = nz_r * vz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_item_r.valid <= 1'b0;
    end else if (en) begin
      s1_item_r <= in_item;
      s1_px_r   <= px_nxt;
      s1_py_r   <= py_nxt;
      s1_pz_r   <= pz_nxt;
      s1_off_r  <= off_r;
      s1_best_r <= in_best;
    end
  end

  assign sum = {{2{s1_px_r[PROD_W-1]}}, s1_px_r} +
               {{2{s1_py_r[PROD_W-1]}}, s1_py_r} +
               {{2{s1_pz_r[PROD_W-1]}}, s1_pz_r};
  assign sum_sh = sum[SUM_W-1:FRAC_BITS];
  assign d_nxt = {{(DIST_W-SH_W){sum_sh[SH_W-1]}}, sum_sh} +
                 {{(DIST_W-COORD_W){s1_off_r[COORD_W-1]}}, s1_off_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_item_r.valid <= 1'b0;
    end else if (en) begin
      s2_item_r <= s1_item_r;
      s2_d_r    <= d_nxt;
      s2_best_r <= s1_best_r;
    end
  end

  assign neg_rad = -{{(DIST_W-COORD_W){s2_item_r.radius[COORD_W-1]}}, s2_item_r.radius};
  assign fail = (s2_item_r.req == REQ_BOX) ? s2_d_r[DIST_W-1] : (s2_d_r < neg_rad);
  assign best_nxt = ((PLANE_IDX == 0) || (s2_d_r < s2_best_r)) ? s2_d_r : s2_best_r;

  always_comb begin
    s3_item_nxt         = s2_item_r;
    s3_item_nxt.in_view = s2_item_r.in_view & ~fail;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_item_r.valid <= 1'b0;
    end else if (en) begin
      s3_item_r <= s3_item_nxt;
      s3_best_r <= best_nxt;
    end
  end

  assign out_item = s3_item_r;
  assign out_best = s3_best_r;

endmodule

`default_nettype wire

/* src/fbsc_out.sv */
`default_nettype none

module fbsc_out #(
  parameter int DIST_W = 51
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire fbsc_pkg::item_t          last_item,
  input  wire logic signed [DIST_W-1:0] last_best,
  input  wire logic                     out_ready,
  output logic                          en,
  output logic                          out_valid,
  output logic                          out_inside_res,
  output logic signed [31:0]            out_nearest_distance
);
  import fbsc_pkg::*;

  logic                      out_valid_r, skid_valid_r;
  logic                      out_inside_r, skid_inside_r;
  coord_t                    out_dist_r, skid_dist_r;
  logic                      push, is_test, res_inside, in_range;
  coord_t                    sat_dist, res_dist;

  assign en   = !skid_valid_r;
  assign push = en && last_item.valid;

  assign is_test  = (last_item.req == REQ_BOX) || (last_item.req == REQ_SPHERE);
  assign in_range = (&last_best[DIST_W-1:COORD_W-1]) || !(|last_best[DIST_W-1:COORD_W-1]);
  assign sat_dist = in_range ? last_best[COORD_W-1:0] :
                    (last_best[DIST_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                         : {1'b0, {(COORD_W-1){1'b1}}});
  assign res_inside = is_test && last_item.in_view;
  assign res_dist   = is_test ? sat_dist : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_ready) begin
      if (push) begin
        skid_valid_r <= 1'b1;
      end
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_ready) begin
      if (push) begin
        skid_inside_r <= res_inside;
        skid_dist_r   <= res_dist;
      end
    end else if (skid_valid_r) begin
      out_inside_r <= skid_inside_r;
      out_dist_r   <= skid_dist_r;
    end else begin
      out_inside_r <= res_inside;
      out_dist_r   <= res_dist;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_inside_res       = out_inside_r;
  assign out_nearest_distance = out_dist_r;

endmodule

`default_nettype wire

/* src/frustum_box_sphere_cull_unit.sv */
`default_nettype none

// Frustum cull unit: one cell per plane, each holding its plane and
// evaluating it in three stages (products, distance, compare/min), with the
// transaction moving cell to cell. Plane writes, box tests and sphere/point
// tests all flow in order down the same chain, so a test always sees every
// write accepted before it. One transaction per cycle is accepted while
// in_ready is high; it passes the input, cell-stage and output registers. A
// two-entry output buffer keeps in_ready high while one result waits;
// in_ready drops only after out_ready is held low with a second result
// ready. All planes are zero after reset. Every transaction, including
// writes, returns one result; writes and unused request codes return zeros.
module frustum_box_sphere_cull_unit #(
  parameter int NUM_PLANES = 6,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_req_type,
  input  wire logic [2:0]         in_plane_slot,
  input  wire logic signed [31:0] in_corner_lo_x,
  input  wire logic signed [31:0] in_corner_lo_y,
  input  wire logic signed [31:0] in_corner_lo_z,
  input  wire logic signed [31:0] in_corner_hi_x,
  input  wire logic signed [31:0] in_corner_hi_y,
  input  wire logic signed [31:0] in_corner_hi_z,
  input  wire logic signed [31:0] in_sphere_radius,
  input  wire logic signed [31:0] in_plane_offset,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_inside_res,
  output logic signed [31:0]      out_nearest_distance
);
  import fbsc_pkg::*;

  localparam int DIST_W = SUM_W - FRAC_BITS + 1;

  logic                      en;
  item_t                     in_item_r;
  item_t                     chain_item [NUM_PLANES+1];
  logic signed [DIST_W-1:0]  chain_best [NUM_PLANES+1];

  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_item_r.valid <= 1'b0;
    end else if (en) begin
      in_item_r.valid   <= in_valid;
      in_item_r.req     <= in_req_type;
      in_item_r.slot    <= in_plane_slot;
      in_item_r.lo_x    <= in_corner_lo_x;
      in_item_r.lo_y    <= in_corner_lo_y;
      in_item_r.lo_z    <= in_corner_lo_z;
      in_item_r.hi_x    <= in_corner_hi_x;
      in_item_r.hi_y    <= in_corner_hi_y;
      in_item_r.hi_z    <= in_corner_hi_z;
      in_item_r.radius  <= in_sphere_radius;
      in_item_r.offset  <= in_plane_offset;
      in_item_r.in_view <= 1'b1;
    end
  end

  assign chain_item[0] = in_item_r;
  assign chain_best[0] = '0;

  for (genvar k = 0; k < NUM_PLANES; k++) begin : g_cell
    fbsc_cell #(
      .PLANE_IDX (k),
      .FRAC_BITS (FRAC_BITS),
      .DIST_W    (DIST_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_item  (chain_item[k]),
      .in_best  (chain_best[k]),
      .out_item (chain_item[k+1]),
      .out_best (chain_best[k+1])
    );
  end

  fbsc_out #(
    .DIST_W (DIST_W)
  ) u_out (
    .clk                  (clk),
    .rst_n                (rst_n),
    .last_item            (chain_item[NUM_PLANES]),
    .last_best            (chain_best[NUM_PLANES]),
    .out_ready            (out_ready),
    .en                   (en),
    .out_valid            (out_valid),
    .out_inside_res       (out_inside_res),
    .out_nearest_distance (out_nearest_distance)
  );

endmodule

`default_nettype wire

/* src/fbsc_checker.sv */
`default_nettype none

module fbsc_checker #(
  parameter int NUM_PLANES = 6
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_inside_res,
  input wire logic signed [31:0] out_nearest_distance
);

  localparam int MAX_PEND = 3 * NUM_PLANES + 3;

  logic [7:0] pend_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 8'(in_acc) - 8'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_inside_res) &&
                                $stable(out_nearest_distance))
    else $error("result dropped or changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 8'd0)
    else $error("result without an outstanding transaction");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 8'(MAX_PEND))
    else $error("more transactions in flight than stages");

  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input stalled without output backpressure");

endmodule

bind frustum_box_sphere_cull_unit fbsc_checker #(
  .NUM_PLANES (NUM_PLANES)
) u_fbsc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_inside_res       (out_inside_res),
  .out_nearest_distance (out_nearest_distance)
);

`default_nettype wire
